@@ rtl/glff_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// glff_pkg - shared types and constants for the graphic LCD frame store
// Command codes, bus instruction bytes, state types and the command/status
// bundles between the controller and the datapath.
// ============================================================================
package glff_pkg;

    // Default panel geometry
    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = 5;

    // Input field positions inside the slave tdata
    localparam int PX_LSB    = 0;
    localparam int PX_W      = 9;
    localparam int PY_LSB    = 9;
    localparam int PY_W      = 8;
    localparam int VALUE_BIT = 17;

    // LCD controller instruction bytes
    localparam logic [7:0] BYTE_SET_COLUMN = 8'h40;
    localparam logic [7:0] BYTE_SET_PAGE   = 8'hB8;
    localparam logic [7:0] BYTE_DISP_ON    = 8'h3F;
    localparam logic [7:0] BYTE_DISP_OFF   = 8'h3E;

    // Chip-select line levels, bit 0 is line one
    localparam logic [1:0] SEL_CHIP0 = 2'b01;
    localparam logic [1:0] SEL_CHIP1 = 2'b10;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_DRAW  = 3'd1,
        CMD_START = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_POWER = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PH_SELECT = 2'd0,
        PH_COLUMN = 2'd1,
        PH_PAGE   = 2'd2,
        PH_DATA   = 2'd3
    } t_flush_phase;

    typedef enum logic [1:0] {
        PW_SEL0   = 2'd0,
        PW_CODE   = 2'd1,
        PW_SEL1   = 2'd2,
        PW_REPEAT = 2'd3
    } t_pwr_step;

    typedef enum logic [2:0] {
        ST_CLEAR      = 3'd0,
        ST_IDLE       = 3'd1,
        ST_DRAW       = 3'd2,
        ST_TICK       = 3'd3,
        ST_PWR_SEL0   = 3'd4,
        ST_PWR_CODE   = 3'd5,
        ST_PWR_SEL1   = 3'd6,
        ST_PWR_REPEAT = 3'd7
    } t_state;

    typedef struct packed {
        logic      clr_init;
        logic      clr_run;
        logic      pix_rd;
        logic      pix_wr;
        logic      flush_start;
        logic      flush_step;
        logic      pwr_cap;
        logic      pwr_emit;
        t_pwr_step pwr_step;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic pix_ok;
        logic clr_last;
        logic slot_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/graphic_lcd_framebuffer_flush_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// graphic_lcd_framebuffer_flush_top - frame store and bus sequencer for a
// two-controller graphic LCD
// Stores one byte per column and page and plays it out as LCD bus strobes.
// ============================================================================
// One command enters per slave transaction (tuser holds the command code).
// Clear zeroes the store, draw sets or clears one pixel (off-panel pixels
// are dropped), start arms a flush, power emits four strobes, and each tick
// during a flush emits one strobe; while a flush runs everything but tick is
// dropped. Items are taken one at a time. The store has a registered read,
// so draw reads the byte and then writes it back, tick reads the store and
// then loads the strobe, power captures its value and then emits its
// strobes, and clear restarts the clearing pass over all PANEL_WIDTH *
// ceil(PANEL_HEIGHT / 8) store bytes, one store byte a cycle. Start, an
// off-panel draw, an idle tick and any dropped command need no further
// step. After reset the same clearing pass runs before the first command
// is accepted. A strobe waits in the master output register until taken;
// the block accepts the next command meanwhile and stalls only when it must
// load a new strobe into a full register.
// ============================================================================
module graphic_lcd_framebuffer_flush_top #(
    parameter int PANEL_WIDTH  = glff_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = glff_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave stream: one command per transaction
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: px[8:0] (signed), py[16:9] (signed), value[17], zero[23:18]
    input  logic [glff_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: cmd[2:0]
    input  logic [glff_pkg::S_TUSER_W-1:0] i_s_tuser,
    // Master stream: one LCD bus strobe per transaction
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: cs_one[0], cs_two[1], data_instr[2], bus_data[10:3], zero[15:11]
    output logic [glff_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tlast: final strobe caused by the command
    output logic                           o_m_tlast,
    // tuser: frame_done[0]
    output logic [glff_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import glff_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: decode commands, hold off input until a command's steps are done
    glff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Store, flush cursors, stale bus levels and the output register
    glff_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/glff_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// glff_datapath - frame store, flush cursors and bus output register
// Holds the byte store, walks it on flush strobes, keeps the stale bus
// levels and drives the master stream register.
// ============================================================================
module glff_datapath #(
    parameter int PANEL_WIDTH  = glff_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = glff_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [glff_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  glff_pkg::t_dp_cmd              i_cmd,
    output glff_pkg::t_dp_status           o_status,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [glff_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast,
    output logic [glff_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import glff_pkg::*;

    localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
    localparam int CHIP_COLS  = PANEL_WIDTH / 2;
    localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W      = $clog2(CHIP_COLS);
    localparam int SUM_W      = ADDR_W + 9;

    logic [7:0]        r_mem [STORE_SIZE];
    logic [7:0]        r_rd_data;

    logic [PX_W-1:0]   w_px;
    logic [PY_W-1:0]   w_py;
    logic              w_value;
    logic              w_pix_ok;
    logic [SUM_W-1:0]  w_pix_sum;
    logic [SUM_W-1:0]  w_flush_sum;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [7:0]        w_wr_data;
    logic              w_wr_en;
    logic              w_load;
    logic              w_slot_free;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_pix_addr;
    logic [7:0]        r_pix_mask;
    logic              r_pix_val;
    logic              r_pwr_on;

    logic              r_busy,  n_busy;
    logic              r_chip,  n_chip;
    logic [PAGE_W-1:0] r_page,  n_page;
    logic [COL_W-1:0]  r_col,   n_col;
    t_flush_phase      r_phase, n_phase;
    logic [7:0]        r_byte,  n_byte;
    logic              r_flag,  n_flag;
    logic [1:0]        r_sel,   n_sel;
    logic              n_last;
    logic              n_done;

    logic              r_out_valid;
    logic [7:0]        r_out_bus;
    logic              r_out_di;
    logic [1:0]        r_out_sel;
    logic              r_out_last;
    logic              r_out_done;

    // Input fields: px signed 9 bits, py signed 8 bits, value
    assign w_px    = i_s_tdata[PX_LSB +: PX_W];
    assign w_py    = i_s_tdata[PY_LSB +: PY_W];
    assign w_value = i_s_tdata[VALUE_BIT];

    assign w_pix_ok = !w_px[PX_W-1] && ({2'b00, w_px[PX_W-2:0]} < 10'(PANEL_WIDTH))
                   && !w_py[PY_W-1] && ({2'b00, w_py[PY_W-2:0]} < 9'(PANEL_HEIGHT));

    assign w_pix_sum = SUM_W'(w_px[PX_W-2:0]) * SUM_W'(PAGE_COUNT)
                     + SUM_W'(w_py[PY_W-2:3]);

    assign w_flush_sum = (SUM_W'(r_chip) * SUM_W'(CHIP_COLS) + SUM_W'(r_col))
                       * SUM_W'(PAGE_COUNT) + SUM_W'(r_page);

    assign w_rd_addr = i_cmd.pix_rd ? w_pix_sum[ADDR_W-1:0] : w_flush_sum[ADDR_W-1:0];

    always_comb begin
        w_wr_en   = i_cmd.clr_run || i_cmd.pix_wr;
        w_wr_addr = i_cmd.clr_run ? r_clr_addr : r_pix_addr;
        if (i_cmd.clr_run) begin
            w_wr_data = 8'h00;
        end else if (r_pix_val) begin
            w_wr_data = r_rd_data | r_pix_mask;
        end else begin
            w_wr_data = r_rd_data & ~r_pix_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_init) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_run) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd) begin
            r_pix_addr <= w_pix_sum[ADDR_W-1:0];
            r_pix_mask <= 8'(1) << w_py[2:0];
            r_pix_val  <= w_value;
        end
        if (i_cmd.pwr_cap) begin
            r_pwr_on <= w_value;
        end
    end

    // Flush sequencing and stale bus levels
    always_comb begin
        n_busy  = r_busy;
        n_chip  = r_chip;
        n_page  = r_page;
        n_col   = r_col;
        n_phase = r_phase;
        n_byte  = r_byte;
        n_flag  = r_flag;
        n_sel   = r_sel;
        n_last  = 1'b0;
        n_done  = 1'b0;
        if (i_cmd.flush_start) begin
            n_busy  = 1'b1;
            n_chip  = 1'b0;
            n_page  = '0;
            n_col   = '0;
            n_phase = PH_SELECT;
        end
        if (i_cmd.flush_step) begin
            n_last = 1'b1;
            unique case (r_phase)
                PH_SELECT: begin
                    n_sel   = r_chip ? SEL_CHIP1 : SEL_CHIP0;
                    n_phase = PH_COLUMN;
                end
                PH_COLUMN: begin
                    n_flag  = 1'b0;
                    n_byte  = BYTE_SET_COLUMN;
                    n_phase = PH_PAGE;
                end
                PH_PAGE: begin
                    n_flag  = 1'b0;
                    n_byte  = BYTE_SET_PAGE | 8'(r_page);
                    n_col   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_flag = 1'b1;
                    n_byte = r_rd_data;
                    if (r_col == COL_W'(CHIP_COLS - 1)) begin
                        n_col = '0;
                        if (r_page == PAGE_W'(PAGE_COUNT - 1)) begin
                            n_page  = '0;
                            n_phase = PH_SELECT;
                            if (r_chip) begin
                                n_chip = 1'b0;
                                n_busy = 1'b0;
                                n_done = 1'b1;
                            end else begin
                                n_chip = 1'b1;
                            end
                        end else begin
                            n_page  = r_page + PAGE_W'(1);
                            n_phase = PH_PAGE;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            endcase
        end
        if (i_cmd.pwr_emit) begin
            n_last = (i_cmd.pwr_step == PW_REPEAT);
            case (i_cmd.pwr_step)
                PW_SEL0: n_sel = SEL_CHIP0;
                PW_CODE: begin
                    n_flag = 1'b0;
                    n_byte = r_pwr_on ? BYTE_DISP_ON : BYTE_DISP_OFF;
                end
                PW_SEL1: n_sel = SEL_CHIP1;
                default: n_sel = r_sel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chip  <= 1'b0;
            r_page  <= '0;
            r_col   <= '0;
            r_phase <= PH_SELECT;
            r_byte  <= 8'h00;
            r_flag  <= 1'b0;
            r_sel   <= 2'b00;
        end else begin
            r_busy  <= n_busy;
            r_chip  <= n_chip;
            r_page  <= n_page;
            r_col   <= n_col;
            r_phase <= n_phase;
            r_byte  <= n_byte;
            r_flag  <= n_flag;
            r_sel   <= n_sel;
        end
    end

    // Output register
    assign w_load      = i_cmd.flush_step || i_cmd.pwr_emit;
    assign w_slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_bus  <= n_byte;
            r_out_di   <= n_flag;
            r_out_sel  <= n_sel;
            r_out_last <= n_last;
            r_out_done <= n_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_out_bus, r_out_di, r_out_sel[1], r_out_sel[0]};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    assign o_status.busy      = r_busy;
    assign o_status.pix_ok    = w_pix_ok;
    assign o_status.clr_last  = (r_clr_addr == ADDR_W'(STORE_SIZE - 1));
    assign o_status.slot_free = w_slot_free;

endmodule
`default_nettype wire

@@ rtl/glff_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// glff_ctrl - command sequencer for the graphic LCD frame store
// Decodes accepted commands and steps the datapath through clearing,
// pixel read-modify-write, flush strobes and the display power sequence.
// ============================================================================
module glff_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic [glff_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_s_tready,
    input  glff_pkg::t_dp_status           i_status,
    output glff_pkg::t_dp_cmd              o_cmd
);
    import glff_pkg::*;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_s_tuser)
                        CMD_CLEAR: if (!i_status.busy) n_state = ST_CLEAR;
                        CMD_DRAW: begin
                            if (!i_status.busy && i_status.pix_ok) n_state = ST_DRAW;
                        end
                        CMD_TICK:  if (i_status.busy) n_state = ST_TICK;
                        CMD_POWER: if (!i_status.busy) n_state = ST_PWR_SEL0;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW: n_state = ST_IDLE;
            ST_TICK: begin
                if (i_status.slot_free) n_state = ST_IDLE;
            end
            ST_PWR_SEL0: begin
                if (i_status.slot_free) n_state = ST_PWR_CODE;
            end
            ST_PWR_CODE: begin
                if (i_status.slot_free) n_state = ST_PWR_SEL1;
            end
            ST_PWR_SEL1: begin
                if (i_status.slot_free) n_state = ST_PWR_REPEAT;
            end
            ST_PWR_REPEAT: begin
                if (i_status.slot_free) n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_run = 1'b1;
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_s_tuser)
                        CMD_CLEAR: o_cmd.clr_init    = !i_status.busy;
                        CMD_DRAW:  o_cmd.pix_rd      = !i_status.busy && i_status.pix_ok;
                        CMD_START: o_cmd.flush_start = !i_status.busy;
                        CMD_POWER: o_cmd.pwr_cap     = !i_status.busy;
                        default:   o_cmd.clr_init    = 1'b0;
                    endcase
                end
            end
            ST_DRAW: o_cmd.pix_wr = 1'b1;
            ST_TICK: o_cmd.flush_step = i_status.slot_free;
            ST_PWR_SEL0: begin
                o_cmd.pwr_emit = i_status.slot_free;
                o_cmd.pwr_step = PW_SEL0;
            end
            ST_PWR_CODE: begin
                o_cmd.pwr_emit = i_status.slot_free;
                o_cmd.pwr_step = PW_CODE;
            end
            ST_PWR_SEL1: begin
                o_cmd.pwr_emit = i_status.slot_free;
                o_cmd.pwr_step = PW_SEL1;
            end
            ST_PWR_REPEAT: begin
                o_cmd.pwr_emit = i_status.slot_free;
                o_cmd.pwr_step = PW_REPEAT;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/glff_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// glff_checker - port-level checks for the graphic LCD frame store
// Watches the stream ports of the top level over time.
// ============================================================================
module glff_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [15:0] o_m_tdata,
    input wire        o_m_tlast,
    input wire [0:0]  o_m_tuser
);

    // Reset empties the output register and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("output valid or input ready right after reset");

    // A stalled strobe holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled strobe changed");

    // The strobe that ends a flush is a data write and the last of its tick
    a_done_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast && o_m_tdata[2])
        else $error("flush completion on a non-data or non-final strobe");

    // Never select both controllers at once
    a_one_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("both chip selects high");

endmodule

bind graphic_lcd_framebuffer_flush_top glff_checker u_glff_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
